[rtl/drp_pkg.sv]
// drp_pkg: types and constants shared by the backend picker modules.
// No dependencies; imported by drp_ctrl, drp_dp and the top level.
package drp_pkg;

    localparam int MAX_BACKENDS = 4;
    localparam int IDX_W        = 2;   // backend index
    localparam int CNT_W        = 3;   // backend count register
    localparam int W_W          = 16;  // Q8.8 weight
    localparam int DEF_W        = 17;  // deficit counter
    localparam int SUM_W        = 18;  // weight total / scaled draw
    localparam int DRAW_W       = 16;

    localparam logic [DEF_W-1:0] UNIT = 17'd256;

    // configuration register indexes
    localparam logic [2:0] REG_COUNT  = 3'd0;
    localparam logic [2:0] REG_POLICY = 3'd1;
    localparam logic [2:0] REG_W0     = 3'd2;
    localparam logic [2:0] REG_W1     = 3'd3;
    localparam logic [2:0] REG_W2     = 3'd4;
    localparam logic [2:0] REG_W3     = 3'd5;

    localparam logic POLICY_DRR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VISIT,
        S_TOTAL,
        S_MUL,
        S_SCAN,
        S_WRAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]                n;      // effective count, 0..4
        logic                            drr;
        logic [MAX_BACKENDS-1:0][W_W-1:0] weight;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic visit;
        logic total;
        logic mul;
        logic scan;
        logic wrap;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic drr;
        logic visit_grant;
        logic visit_last;
        logic scan_hit;
        logic scan_avail;
        logic scan_last;
        logic wrap_avail;
        logic wrap_last;
    } t_stat;

endpackage

[rtl/drp_ctrl.sv]
// drp_ctrl: sequencing state machine of the backend picker.
// Depends on drp_pkg; drives drp_dp through t_cmd and reads t_stat.
module drp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    input  drp_pkg::t_stat i_stat,
    output drp_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_emit
);
    import drp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.n_zero)   n_state = S_DONE;
                    else if (i_stat.drr) n_state = S_VISIT;
                    else                 n_state = S_TOTAL;
                end
            end
            S_VISIT: begin
                o_cmd.visit = 1'b1;
                if (i_stat.visit_grant)     n_state = S_DONE;
                else if (i_stat.visit_last) n_state = S_TOTAL;
            end
            S_TOTAL: begin
                o_cmd.total = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit && i_stat.scan_avail) n_state = S_DONE;
                else if (i_stat.scan_hit || i_stat.scan_last) n_state = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                if (i_stat.wrap_avail || i_stat.wrap_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/drp_dp.sv]
// drp_dp: datapath of the backend picker - deficits, pointer, weighted pick.
// Depends on drp_pkg; commanded by drp_ctrl.
module drp_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  drp_pkg::t_cfg                i_cfg,
    input  drp_pkg::t_cmd                i_cmd,
    input  logic [drp_pkg::MAX_BACKENDS-1:0] i_mask,
    input  logic [drp_pkg::DRAW_W-1:0]   i_draw,
    output drp_pkg::t_stat               o_stat,
    output logic                         o_granted,
    output logic [drp_pkg::IDX_W-1:0]    o_index,
    output logic                         o_fallback
);
    import drp_pkg::*;

    // small sum reduced modulo n (n in 1..4, sum below 11)
    function automatic logic [IDX_W-1:0] mod_n(input logic [3:0] s,
                                               input logic [CNT_W-1:0] n);
        logic [3:0] t;
        begin
            t = s;
            case (n)
                3'd2: t = {3'b000, s[0]};
                3'd3: begin
                    if (t >= 4'd6) t = t - 4'd6;
                    if (t >= 4'd3) t = t - 4'd3;
                end
                3'd4: t = {2'b00, s[1:0]};
                default: t = 4'd0;
            endcase
            mod_n = t[IDX_W-1:0];
        end
    endfunction

    logic [DEF_W-1:0]  r_def [MAX_BACKENDS];
    logic [IDX_W-1:0]  r_ptr;
    logic [2:0]        r_visit;
    logic [MAX_BACKENDS-1:0] r_mask;
    logic [DRAW_W-1:0] r_draw;
    logic [SUM_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_sel;
    logic [IDX_W-1:0]  r_scan;
    logic [IDX_W-1:0]  r_wrap_cnt;
    logic              r_granted;
    logic [IDX_W-1:0]  r_index;
    logic              r_fallback;

    logic [IDX_W-1:0]  visit_idx, ptr_inc, scan_inc, scan_start;
    logic [DEF_W-1:0]  def_cur;
    logic [W_W-1:0]    w_visit, w_scan;
    logic [CNT_W-1:0]  n_m1;
    logic [SUM_W-1:0]  total_sum;
    logic [33:0]       prod;
    logic              def_ok;

    assign n_m1      = i_cfg.n - 3'd1;
    assign visit_idx = mod_n({2'b00, r_ptr} + {1'b0, r_visit}, i_cfg.n);
    assign ptr_inc   = mod_n({2'b00, r_ptr} + 4'd1, i_cfg.n);
    assign def_cur   = r_def[visit_idx];
    assign def_ok    = (def_cur >= UNIT);
    assign w_visit   = i_cfg.weight[visit_idx];
    assign w_scan    = i_cfg.weight[r_scan];
    assign scan_inc  = mod_n({2'b00, r_scan} + 4'd1, i_cfg.n);
    // no hit: scan ends at n - 1, wrap starts at (n + 1) mod n
    assign scan_start = o_stat.scan_hit ? scan_inc
                                        : mod_n({2'b00, r_scan} + 4'd2, i_cfg.n);

    always_comb begin
        total_sum = '0;
        for (int k = 0; k < MAX_BACKENDS; k++) begin
            if (k < int'(i_cfg.n)) total_sum = total_sum + {2'b00, i_cfg.weight[k]};
        end
    end

    assign prod = {18'd0, r_draw} * {16'd0, r_total};

    always_comb begin
        o_stat.n_zero      = (i_cfg.n == '0);
        o_stat.drr         = (i_cfg.drr == POLICY_DRR);
        o_stat.visit_grant = def_ok && r_mask[visit_idx];
        o_stat.visit_last  = ({1'b0, r_visit} == ({i_cfg.n, 1'b0} - 4'd1));
        o_stat.scan_hit    = (r_sel < {2'b00, w_scan});
        o_stat.scan_avail  = r_mask[r_scan];
        o_stat.scan_last   = ({1'b0, r_scan} == n_m1);
        o_stat.wrap_avail  = r_mask[r_scan];
        o_stat.wrap_last   = ({1'b0, r_wrap_cnt} == n_m1);
    end

    // control state: deficits and pointer persist across requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BACKENDS; k++) r_def[k] <= '0;
            r_ptr <= '0;
        end else if (i_cmd.load) begin
            if (i_cfg.n != '0) r_ptr <= mod_n({2'b00, r_ptr}, i_cfg.n);
        end else if (i_cmd.visit) begin
            if (o_stat.visit_grant) begin
                r_def[visit_idx] <= def_cur - UNIT;
            end else begin
                if (!def_ok) r_def[visit_idx] <= def_cur + {1'b0, w_visit};
                r_ptr <= ptr_inc;
            end
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask     <= i_mask;
            r_draw     <= i_draw;
            r_visit    <= '0;
            r_granted  <= 1'b0;
            r_index    <= '0;
            r_fallback <= 1'b0;
        end
        if (i_cmd.visit) begin
            r_visit <= r_visit + 3'd1;
            if (o_stat.visit_grant) begin
                r_granted <= 1'b1;
                r_index   <= visit_idx;
            end
        end
        if (i_cmd.total) r_total <= total_sum;
        if (i_cmd.mul) begin
            r_sel  <= prod[33:16];
            r_scan <= '0;
        end
        if (i_cmd.scan) begin
            if (o_stat.scan_hit && o_stat.scan_avail) begin
                r_granted  <= 1'b1;
                r_index    <= r_scan;
                r_fallback <= 1'b1;
            end else if (o_stat.scan_hit || o_stat.scan_last) begin
                r_scan     <= scan_start;
                r_wrap_cnt <= '0;
            end else begin
                r_sel  <= r_sel - {2'b00, w_scan};
                r_scan <= scan_inc;
            end
        end
        if (i_cmd.wrap) begin
            if (o_stat.wrap_avail) begin
                r_granted  <= 1'b1;
                r_index    <= r_scan;
                r_fallback <= 1'b1;
            end else begin
                r_scan     <= scan_inc;
                r_wrap_cnt <= r_wrap_cnt + 2'd1;
            end
        end
    end

    assign o_granted  = r_granted;
    assign o_index    = r_index;
    assign o_fallback = r_fallback;

endmodule

[rtl/deficit_round_robin_backend_picker_unit.sv]
// Backend picker top level: configuration registers, output register,
// controller and datapath. Depends on drp_pkg, drp_ctrl and drp_dp.
//
// Each request beat picks at most one backend by deficit round robin (policy 1)
// with a weighted random fallback, or by weighted random alone (policy 0). A
// request is accepted, then makes up to 2n deficit visits (one per cycle), then,
// when the fallback runs, forms the weight total and the scaled draw, scans up
// to n prefix sums and up to n wrap entries, and then hands the result to the
// output register once that is free. The deficit loop and the scans run
// serially, one step after another.
// A new request is accepted only when the previous one has moved to the output
// register; the output register holds a result while the next request runs.
module deficit_round_robin_backend_picker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] available_mask, [19:4] random_draw
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] backend_index
    output logic [1:0]  m_axis_tuser,   // [0] granted, [1] used_fallback
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import drp_pkg::*;

    // configuration registers
    logic [CNT_W-1:0] r_count;
    logic             r_policy;
    logic [MAX_BACKENDS-1:0][W_W-1:0] r_weight;

    // output register
    logic             r_out_valid;
    logic             r_out_granted;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_fallback;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready, emit, out_free;
    logic  dp_granted, dp_fallback;
    logic [IDX_W-1:0] dp_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 3'd4;
            r_policy <= POLICY_DRR;
            for (int k = 0; k < MAX_BACKENDS; k++) r_weight[k] <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COUNT:  r_count     <= i_cfg_data[CNT_W-1:0];
                REG_POLICY: r_policy    <= i_cfg_data[0];
                REG_W0:     r_weight[0] <= i_cfg_data;
                REG_W1:     r_weight[1] <= i_cfg_data;
                REG_W2:     r_weight[2] <= i_cfg_data;
                REG_W3:     r_weight[3] <= i_cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // counts above the backend limit act as the limit
    always_comb begin
        cfg.n      = (r_count > CNT_W'(MAX_BACKENDS)) ? CNT_W'(MAX_BACKENDS) : r_count;
        cfg.drr    = r_policy;
        cfg.weight = r_weight;
    end

    assign out_free = !r_out_valid || m_axis_tready;

    drp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready),
        .o_emit     (emit)
    );

    drp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .i_mask     (s_axis_tdata[3:0]),
        .i_draw     (s_axis_tdata[19:4]),
        .o_stat     (stat),
        .o_granted  (dp_granted),
        .o_index    (dp_index),
        .o_fallback (dp_fallback)
    );

    assign s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= emit || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_granted  <= dp_granted;
            r_out_index    <= dp_index;
            r_out_fallback <= dp_fallback;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_index};
    assign m_axis_tuser  = {r_out_fallback, r_out_granted};

    // after an accepted request the block is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

    // no grant carries a zero index and no fallback flag
    a_no_grant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (m_axis_tdata[1:0] == 2'd0 && !m_axis_tuser[1]))
        else $error("ungranted result carries index or fallback flag");

    // the fallback flag only comes with a grant
    a_fallback_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("fallback flag without grant");

endmodule
